// ===== rtl/sfdft_pkg.sv =====
package sfdft_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int ADDR_BITS = $clog2(MAX_SAMPLES);
	localparam int CNT_BITS = ADDR_BITS + 1;
	localparam int MAX_BINS = 64;
	localparam int BIN_BITS = 6;
	localparam int SAMPLE_BITS = 16;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int TBL_SIZE = 1 << TABLE_ADDR_BITS;
	localparam int ACC_BITS = 42;
	localparam int PROD_BITS = SAMPLE_BITS + 17;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_STEP = 2'd1;
	localparam logic [1:0] REG_NSTEPS = 2'd2;

	typedef logic signed [16:0] q15_t;

	// restoring long division, used only while building the constant table
	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Taylor series in Q30, truncating steps, clamped and scaled to Q15
	function automatic q15_t series_q15(input logic [63:0] x, input logic is_sine);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] d;
		logic signed [63:0] sum;
		logic [63:0] r;
		x2 = (x * x) >> 30;
		term = is_sine ? x : 64'd1 << 30;
		d = is_sine ? 64'd2 : 64'd1;
		sum = '0;
		for (int i = 0; i < 10; i++) begin
			if (i[0]) sum = sum - $signed(term);
			else sum = sum + $signed(term);
			term = long_div((term * x2) >> 30, d * (d + 64'd1));
			d = d + 64'd2;
		end
		if (sum < 0) sum = '0;
		if (sum > 64'sd1073741824) sum = 64'sd1073741824;
		r = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		return q15_t'(r[16:0]);
	endfunction

	function automatic q15_t tbl_lookup(input logic [TABLE_ADDR_BITS-1:0] k,
			input logic want_sin);
		logic [1:0] q;
		logic [63:0] t;
		q15_t s;
		q15_t c;
		q15_t v;
		q = k[TABLE_ADDR_BITS-1 -: 2];
		t = (64'd3373259426 * 64'(k[TABLE_ADDR_BITS-3:0])) >> (TABLE_ADDR_BITS - 1);
		s = series_q15(t, 1'b1);
		c = series_q15(t, 1'b0);
		case (q)
			2'd0: v = want_sin ? s : c;
			2'd1: v = want_sin ? c : -s;
			2'd2: v = want_sin ? -s : -c;
			default: v = want_sin ? -c : s;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/sfdft_ram.sv =====
module sfdft_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/sfdft_trig_rom.sv =====
module sfdft_trig_rom (
	input logic clk,
	input logic [sfdft_pkg::TABLE_ADDR_BITS-1:0] addr,
	output sfdft_pkg::q15_t cos_q,
	output sfdft_pkg::q15_t sin_q
);
	sfdft_pkg::q15_t cos_tbl [sfdft_pkg::TBL_SIZE];
	sfdft_pkg::q15_t sin_tbl [sfdft_pkg::TBL_SIZE];

	always_comb begin
		for (int k = 0; k < sfdft_pkg::TBL_SIZE; k++) begin
			cos_tbl[k] = sfdft_pkg::tbl_lookup(sfdft_pkg::TABLE_ADDR_BITS'(k), 1'b0);
			sin_tbl[k] = sfdft_pkg::tbl_lookup(sfdft_pkg::TABLE_ADDR_BITS'(k), 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		cos_q <= cos_tbl[addr];
		sin_q <= sin_tbl[addr];
	end
endmodule

// ===== rtl/swept_frequency_dft_unit.sv =====
// Swept-frequency direct DFT.
// Input stream s_axis: one 16-bit signed sample per word (tdata), tlast marks
// the last sample of a frame. Samples go into a 1024-entry store; beyond that
// they are dropped. A word with tlast starts the sweep over num_steps+1 bins.
// Output stream m_axis: one word per bin, tdata = {imag, real, bin_index},
// tlast on the final bin.
// Each stored sample passes once per bin through the shared complex
// multiply-accumulate; each bin adds setup, pipeline drain and result
// hand-off, and output handshakes add to the sweep that follows tlast.
// A sample word without tlast leaves the block ready for the next word. The block is not ready
// while sweeping or while a result word waits in the output register.
// When the receiver stalls, the result holds in the output register and the
// sweep waits. Reset clears counters and config (num_steps = 1); the store
// needs no clearing since only samples written in the current frame are read.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once; issue them
// only while idle.
module swept_frequency_dft_unit (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [15:0] s_axis_tdata, // [15:0] sample
	input logic s_axis_tlast,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [95:0] m_axis_tdata, // [5:0] bin_index, [47:6] real, [89:48] imag
	output logic m_axis_tlast,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_BIN = 2'd1;
	localparam logic [1:0] ST_RUN = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;
	localparam int AB = sfdft_pkg::ADDR_BITS;
	localparam int CB = sfdft_pkg::CNT_BITS;
	localparam int BB = sfdft_pkg::BIN_BITS;
	localparam int XB = sfdft_pkg::ACC_BITS;

	logic [1:0] state_q;
	logic [31:0] start_q, step_q, inc_q, phase_q;
	logic [BB-1:0] nsteps_q, bin_q;
	logic [CB-1:0] count_q, n_q;
	logic signed [XB-1:0] re_q, im_q;
	// pipeline valid: s1 = ram/rom read, s2 = products
	logic v_s1, v_s2;
	logic signed [sfdft_pkg::PROD_BITS-1:0] pre_s2, pim_s2;
	logic [15:0] rdata;
	sfdft_pkg::q15_t cos_v, sin_v;
	logic in_acc, store_we;
	logic out_v_q;
	logic [BB-1:0] out_bin_q;
	logic signed [XB-1:0] out_re_q, out_im_q;
	logic out_last_q;
	logic last_bin;

	assign s_axis_tready = (state_q == ST_LOAD) && !out_v_q;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign store_we = in_acc && (count_q < CB'(sfdft_pkg::MAX_SAMPLES));
	assign last_bin = (bin_q == nsteps_q) || (bin_q == BB'(sfdft_pkg::MAX_BINS - 1));

	sfdft_ram #(.WIDTH(16), .DEPTH(sfdft_pkg::MAX_SAMPLES)) u_store (
		.clk(clk), .we(store_we), .waddr(count_q[AB-1:0]), .wdata(s_axis_tdata),
		.raddr(n_q[AB-1:0]), .rdata(rdata)
	);

	sfdft_trig_rom u_rom (
		.clk(clk), .addr(phase_q[31 -: sfdft_pkg::TABLE_ADDR_BITS]),
		.cos_q(cos_v), .sin_q(sin_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			start_q <= '0;
			step_q <= '0;
			nsteps_q <= BB'(1);
			count_q <= '0;
			n_q <= '0;
			bin_q <= '0;
			inc_q <= '0;
			phase_q <= '0;
			re_q <= '0;
			im_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_v_q <= 1'b0;
			out_bin_q <= '0;
			out_re_q <= '0;
			out_im_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sfdft_pkg::REG_START: start_q <= cfg_data;
					sfdft_pkg::REG_STEP: step_q <= cfg_data;
					sfdft_pkg::REG_NSTEPS: nsteps_q <= cfg_data[BB-1:0];
					default: ;
				endcase
			end
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			v_s1 <= (state_q == ST_RUN) && (n_q < count_q);
			v_s2 <= v_s1;
			if (v_s2) begin
				re_q <= re_q + XB'(pre_s2);
				im_q <= im_q - XB'(pim_s2);
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (store_we) count_q <= count_q + CB'(1);
						if (s_axis_tlast) begin
							state_q <= ST_BIN;
							bin_q <= '0;
							inc_q <= start_q;
						end
					end
				end
				ST_BIN: begin
					phase_q <= '0;
					n_q <= '0;
					re_q <= '0;
					im_q <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (n_q < count_q) begin
						n_q <= n_q + CB'(1);
						phase_q <= phase_q + inc_q;
					end else if (!v_s1 && !v_s2 && !out_v_q) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					out_v_q <= 1'b1;
					out_bin_q <= bin_q;
					out_re_q <= re_q;
					out_im_q <= im_q;
					out_last_q <= last_bin;
					if (last_bin) begin
						state_q <= ST_LOAD;
						count_q <= '0;
					end else begin
						state_q <= ST_BIN;
						bin_q <= bin_q + BB'(1);
						inc_q <= inc_q + step_q;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// rom and ram addresses move together: phase_q is sampled with the ram address
	always_ff @(posedge clk) begin
		pre_s2 <= $signed(rdata) * cos_v;
		pim_s2 <= $signed(rdata) * sin_v;
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {6'd0, out_im_q, out_re_q, out_bin_q};
	assign m_axis_tlast = out_last_q;

`ifndef SYNTHESIS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !s_axis_tready) else $error("ready while busy");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CB'(sfdft_pkg::MAX_SAMPLES)) else $error("count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_axis_tready) |=> out_v_q) else $error("result lost");
	a_pipe_run: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_RUN)) else $error("mac outside run");
`endif
endmodule
